// ----- hdl/mtep_pkg.sv -----
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types and codes for the MIDI track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

	localparam logic [15:0] EVENT_LIMIT_RESET = 16'd8192;

	// event kinds
	localparam logic [2:0] KIND_NOTE_OFF   = 3'd0;
	localparam logic [2:0] KIND_NOTE_ON    = 3'd1;
	localparam logic [2:0] KIND_PROGRAM    = 3'd2;
	localparam logic [2:0] KIND_CONTROLLER = 3'd3;
	localparam logic [2:0] KIND_TEMPO      = 3'd4;
	localparam logic [2:0] KIND_END        = 3'd5;

	// end causes
	localparam logic [1:0] CAUSE_END_OF_TRACK = 2'd0;
	localparam logic [1:0] CAUSE_BAD_TAG      = 2'd1;
	localparam logic [1:0] CAUSE_NO_STATUS    = 2'd2;
	localparam logic [1:0] CAUSE_LIMIT        = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [3:0]  channel;
		logic [23:0] first_param;
		logic [7:0]  second_param;
		logic [31:0] tick;
		logic [1:0]  end_cause;
		logic        last_of_run;
	} result_t;

endpackage

// ----- hdl/mtep_parse_core.sv -----
// ----------------------------------------------------------------------------
// mtep_parse_core
// Parse state registers and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module mtep_parse_core (
	input  logic                clk,
	input  logic                arst_n,
	input  mtep_pkg::item_t     item,
	input  logic                fire,
	input  logic [15:0]         event_limit,
	output mtep_pkg::result_t   res0,
	output mtep_pkg::result_t   res1,
	output logic [1:0]          res_count
);

	localparam logic [3:0] PH_HEADER = 4'd0;
	localparam logic [3:0] PH_DELTA  = 4'd1;
	localparam logic [3:0] PH_STATUS = 4'd2;
	localparam logic [3:0] PH_DATA1  = 4'd3;
	localparam logic [3:0] PH_DATA2  = 4'd4;
	localparam logic [3:0] PH_PROG   = 4'd5;
	localparam logic [3:0] PH_MTYPE  = 4'd6;
	localparam logic [3:0] PH_MLEN   = 4'd7;
	localparam logic [3:0] PH_TEMPO  = 4'd8;
	localparam logic [3:0] PH_SKIP   = 4'd9;

	localparam logic [3:0] ST_NOTE_OFF = 4'h8;
	localparam logic [3:0] ST_NOTE_ON  = 4'h9;
	localparam logic [3:0] ST_CTRL     = 4'hB;
	localparam logic [3:0] ST_PROG     = 4'hC;
	localparam logic [7:0] ST_META     = 8'hFF;
	localparam logic [7:0] META_TEMPO  = 8'h51;
	localparam logic [7:0] META_EOT    = 8'h2F;
	localparam logic [4:0] HDR_LAST    = 5'd21;

	logic [4:0]  pos_q;
	logic [3:0]  phase_q;
	logic [7:0]  rs_q;
	logic [27:0] delta_q;
	logic [31:0] tick_q;
	logic [7:0]  held_q;
	logic [7:0]  meta_q;
	logic [27:0] skip_q;
	logic [23:0] tempo_q;
	logic [15:0] count_q;
	logic        fin_q;

	logic [4:0]  cur_pos, nxt_pos;
	logic [3:0]  cur_phase, nxt_phase, eff_phase;
	logic [7:0]  cur_rs, nxt_rs;
	logic [27:0] cur_delta, nxt_delta;
	logic [31:0] cur_tick, nxt_tick;
	logic [7:0]  cur_held, nxt_held;
	logic [7:0]  cur_meta, nxt_meta;
	logic [27:0] cur_skip, nxt_skip, eff_skip;
	logic [23:0] cur_tempo, nxt_tempo;
	logic [15:0] cur_count, nxt_count;
	logic        cur_fin, nxt_fin;

	logic [7:0]  b;
	logic [27:0] vlq;
	logic [23:0] tempo_sh;
	logic [4:0]  pos_inc;
	logic        ev_valid;
	logic [2:0]  ev_kind;
	logic [3:0]  ev_channel;
	logic [23:0] ev_first;
	logic [7:0]  ev_second;
	logic        end_valid;
	logic [1:0]  end_cause;
	mtep_pkg::result_t ev_res, end_res;

	// phase that a status byte leads to
	function automatic logic [3:0] status_phase(input logic [7:0] s);
		logic [3:0] p;
		if (s[7:4] == ST_NOTE_OFF || s[7:4] == ST_NOTE_ON || s[7:4] == ST_CTRL)
			p = PH_DATA1;
		else if (s[7:4] == ST_PROG)
			p = PH_PROG;
		else if (s == ST_META)
			p = PH_MTYPE;
		else
			p = PH_SKIP;
		return p;
	endfunction

	function automatic logic [7:0] tag_byte(input logic [1:0] i);
		logic [7:0] t;
		unique case (i)
			2'd0: t = 8'h4D;
			2'd1: t = 8'h54;
			2'd2: t = 8'h68;
			default: t = 8'h64;
		endcase
		return t;
	endfunction

	assign b = item.data_byte;

	always_comb begin
		if (item.start_of_file) begin
			cur_pos   = '0;
			cur_phase = PH_HEADER;
			cur_rs    = '0;
			cur_delta = '0;
			cur_tick  = '0;
			cur_held  = '0;
			cur_meta  = '0;
			cur_skip  = '0;
			cur_tempo = '0;
			cur_count = '0;
			cur_fin   = 1'b0;
		end else begin
			cur_pos   = pos_q;
			cur_phase = phase_q;
			cur_rs    = rs_q;
			cur_delta = delta_q;
			cur_tick  = tick_q;
			cur_held  = held_q;
			cur_meta  = meta_q;
			cur_skip  = skip_q;
			cur_tempo = tempo_q;
			cur_count = count_q;
			cur_fin   = fin_q;
		end
	end

	// a data byte where a status is due reuses the running status
	always_comb begin
		eff_phase = cur_phase;
		eff_skip  = cur_skip;
		if (cur_phase == PH_STATUS && !b[7] && cur_rs != 8'd0) begin
			eff_phase = status_phase(cur_rs);
			if (eff_phase == PH_SKIP)
				eff_skip = 28'd2;
		end
	end

	assign vlq      = {cur_skip[20:0], b[6:0]};
	assign tempo_sh = {cur_tempo[15:0], b};
	assign pos_inc  = cur_pos + 5'd1;

	always_comb begin
		nxt_pos    = cur_pos;
		nxt_phase  = cur_phase;
		nxt_rs     = cur_rs;
		nxt_delta  = cur_delta;
		nxt_tick   = cur_tick;
		nxt_held   = cur_held;
		nxt_meta   = cur_meta;
		nxt_skip   = cur_skip;
		nxt_tempo  = cur_tempo;
		nxt_count  = cur_count;
		nxt_fin    = cur_fin;
		ev_valid   = 1'b0;
		ev_kind    = mtep_pkg::KIND_NOTE_OFF;
		ev_channel = '0;
		ev_first   = '0;
		ev_second  = '0;
		end_valid  = 1'b0;
		end_cause  = mtep_pkg::CAUSE_END_OF_TRACK;
		if (!cur_fin) begin
			unique case (eff_phase)
				PH_HEADER: begin
					if (cur_pos < 5'd4 && b != tag_byte(cur_pos[1:0])) begin
						end_valid = 1'b1;
						end_cause = mtep_pkg::CAUSE_BAD_TAG;
					end else if (cur_pos >= HDR_LAST) begin
						nxt_phase = PH_DELTA;
					end else begin
						nxt_pos = pos_inc;
					end
				end
				PH_DELTA: begin
					if (!b[7]) begin
						nxt_tick  = cur_tick + {4'd0, cur_delta[20:0], b[6:0]};
						nxt_delta = '0;
						nxt_phase = PH_STATUS;
					end else begin
						nxt_delta = {cur_delta[20:0], b[6:0]};
					end
				end
				PH_STATUS: begin
					if (b[7]) begin
						nxt_rs    = b;
						nxt_phase = status_phase(b);
						if (status_phase(b) == PH_SKIP)
							nxt_skip = 28'd2;
					end else begin
						end_valid = 1'b1;
						end_cause = mtep_pkg::CAUSE_NO_STATUS;
					end
				end
				PH_DATA1: begin
					nxt_held  = b;
					nxt_phase = PH_DATA2;
				end
				PH_DATA2: begin
					ev_valid   = 1'b1;
					ev_channel = cur_rs[3:0];
					ev_first   = {16'd0, cur_held};
					ev_second  = b;
					if (cur_rs[7:4] == ST_CTRL)
						ev_kind = mtep_pkg::KIND_CONTROLLER;
					else if (cur_rs[7:4] == ST_NOTE_OFF || b == 8'd0)
						ev_kind = mtep_pkg::KIND_NOTE_OFF;
					else
						ev_kind = mtep_pkg::KIND_NOTE_ON;
				end
				PH_PROG: begin
					ev_valid   = 1'b1;
					ev_kind    = mtep_pkg::KIND_PROGRAM;
					ev_channel = cur_rs[3:0];
					ev_first   = {16'd0, b};
				end
				PH_MTYPE: begin
					nxt_meta  = b;
					nxt_skip  = '0;
					nxt_phase = PH_MLEN;
				end
				PH_MLEN: begin
					nxt_skip = vlq;
					if (!b[7]) begin
						if (cur_meta == META_TEMPO && vlq == 28'd3) begin
							nxt_tempo = '0;
							nxt_pos   = '0;
							nxt_phase = PH_TEMPO;
						end else if (cur_meta == META_EOT) begin
							end_valid = 1'b1;
							end_cause = mtep_pkg::CAUSE_END_OF_TRACK;
						end else if (vlq == 28'd0) begin
							nxt_phase = PH_DELTA;
						end else begin
							nxt_phase = PH_SKIP;
						end
					end
				end
				PH_TEMPO: begin
					nxt_tempo = tempo_sh;
					nxt_pos   = pos_inc;
					if (pos_inc >= 5'd3) begin
						ev_valid = 1'b1;
						ev_kind  = mtep_pkg::KIND_TEMPO;
						ev_first = tempo_sh;
					end
				end
				PH_SKIP: begin
					nxt_skip = (eff_skip != 28'd0) ? eff_skip - 28'd1 : eff_skip;
					nxt_phase = PH_SKIP;
					if (eff_skip <= 28'd1)
						nxt_phase = PH_DELTA;
				end
				default: begin
					nxt_phase = PH_DELTA;
				end
			endcase
			if (ev_valid) begin
				nxt_count = cur_count + 16'd1;
				nxt_phase = PH_DELTA;
				if (cur_count + 16'd1 >= event_limit) begin
					end_valid = 1'b1;
					end_cause = mtep_pkg::CAUSE_LIMIT;
				end
			end
			// input ran out before the track closed
			if (item.last_byte && !end_valid) begin
				end_valid = 1'b1;
				end_cause = mtep_pkg::CAUSE_LIMIT;
			end
			if (end_valid)
				nxt_fin = 1'b1;
		end
	end

	always_comb begin
		ev_res.event_kind   = ev_kind;
		ev_res.channel      = ev_channel;
		ev_res.first_param  = ev_first;
		ev_res.second_param = ev_second;
		ev_res.tick         = nxt_tick;
		ev_res.end_cause    = mtep_pkg::CAUSE_END_OF_TRACK;
		ev_res.last_of_run  = !end_valid;
		end_res.event_kind   = mtep_pkg::KIND_END;
		end_res.channel      = '0;
		end_res.first_param  = '0;
		end_res.second_param = '0;
		end_res.tick         = nxt_tick;
		end_res.end_cause    = end_cause;
		end_res.last_of_run  = 1'b1;
		res0      = ev_valid ? ev_res : end_res;
		res1      = end_res;
		res_count = {1'b0, ev_valid} + {1'b0, end_valid};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= PH_HEADER;
			rs_q    <= '0;
			delta_q <= '0;
			tick_q  <= '0;
			held_q  <= '0;
			meta_q  <= '0;
			skip_q  <= '0;
			tempo_q <= '0;
			count_q <= '0;
			fin_q   <= 1'b0;
		end else if (fire) begin
			pos_q   <= nxt_pos;
			phase_q <= nxt_phase;
			rs_q    <= nxt_rs;
			delta_q <= nxt_delta;
			tick_q  <= nxt_tick;
			held_q  <= nxt_held;
			meta_q  <= nxt_meta;
			skip_q  <= nxt_skip;
			tempo_q <= nxt_tempo;
			count_q <= nxt_count;
			fin_q   <= nxt_fin;
		end
	end

endmodule

// ----- hdl/mtep_out_queue.sv -----
// ----------------------------------------------------------------------------
// mtep_out_queue
// Two-slot result queue between the parse core and the output stream.
// ----------------------------------------------------------------------------
module mtep_out_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [1:0]         push_count,
	input  mtep_pkg::result_t  res0,
	input  mtep_pkg::result_t  res1,
	input  logic               pop_ready,
	output logic               head_valid,
	output mtep_pkg::result_t  head,
	output logic [1:0]         room
);

	logic [1:0]        cnt_q;
	mtep_pkg::result_t slot_a_q, slot_b_q;
	logic              pop;
	logic [1:0]        rem;
	logic [1:0]        add;
	mtep_pkg::result_t rem_a;

	assign head_valid = cnt_q != 2'd0;
	assign head       = slot_a_q;
	assign pop        = head_valid && pop_ready;
	assign rem        = cnt_q - {1'b0, pop};
	assign room       = 2'd2 - rem;
	assign add        = push ? push_count : 2'd0;
	assign rem_a      = pop ? slot_b_q : slot_a_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else
			cnt_q <= rem + add;
	end

	// pack survivors first, then the new results
	always_ff @(posedge clk) begin
		if (rem == 2'd0) begin
			slot_a_q <= res0;
			slot_b_q <= res1;
		end else if (rem == 2'd1) begin
			slot_a_q <= rem_a;
			slot_b_q <= res0;
		end
	end

endmodule

// ----- hdl/midi_track_event_parser_unit.sv -----
// ----------------------------------------------------------------------------
// midi_track_event_parser_unit
// Byte-serial Standard MIDI File track parser with stream ports.
// ----------------------------------------------------------------------------
// One file byte is taken per clock while the output queue has room for its
// results. A byte goes into an input register, is decoded against the parse
// state in one pass, and its results land in a two-slot output queue when it
// leaves the input register; m_tdata shows the queue head. A byte gives at
// most two results (an event followed by the end event). While m_tready stays
// high the queue drains one beat per cycle and bytes stream at one per clock
// with no gap. The input register holds its byte only while the queue has no
// room for that byte's results, so output back-pressure reaches s_tready in
// the same cycle. cfg_data sets the event limit (reset 8192) and is taken at
// any cycle; write it only while idle.
module midi_track_event_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] start_of_file
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [3:0] channel, [27:4] first_param,
	                               // [35:28] second_param, [67:36] tick,
	                               // [69:68] end_cause, [71:70] zero
	output logic [2:0]  m_tuser,   // [2:0] event_kind
	output logic        m_tlast,   // last_of_run
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic              valid_s1;
	mtep_pkg::item_t   item_s1;
	logic [15:0]       limit_q;
	logic              fire;
	mtep_pkg::result_t res0, res1, head;
	logic [1:0]        res_count;
	logic [1:0]        room;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= mtep_pkg::EVENT_LIMIT_RESET;
		else if (cfg_valid)
			limit_q <= cfg_data;
	end

	// advance the input register when its byte is consumed
	assign fire     = valid_s1 && (res_count <= room);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.data_byte     <= s_tdata;
			item_s1.start_of_file <= s_tuser;
			item_s1.last_byte     <= s_tlast;
		end
	end

	mtep_parse_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_s1),
		.fire        (fire),
		.event_limit (limit_q),
		.res0        (res0),
		.res1        (res1),
		.res_count   (res_count)
	);

	mtep_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fire),
		.push_count (res_count),
		.res0       (res0),
		.res1       (res1),
		.pop_ready  (m_tready),
		.head_valid (m_tvalid),
		.head       (head),
		.room       (room)
	);

	assign m_tdata = {2'b00, head.end_cause, head.tick, head.second_param,
		head.first_param, head.channel};
	assign m_tuser = head.event_kind;
	assign m_tlast = head.last_of_run;

endmodule
